// ===== rtl/core/fbpa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and codes of the fixed block pool allocator: request and
// result words, status codes, register indexes and sequencer types.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 48;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CHUNK_BYTES   = 2'd0,
        CFG_CHUNKS_IN_USE = 2'd1,
        CFG_POOL_BASE     = 2'd2
    } fbpa_cfg_index_t;

    // register reset values
    localparam logic [31:0] CHUNK_BYTES_RESET   = 32'd250000000;
    localparam logic [6:0]  CHUNKS_IN_USE_RESET = 7'd4;
    localparam logic [47:0] POOL_BASE_RESET     = 48'd0;

    // request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_TOO_LARGE  = 2'd1;
    localparam logic [1:0] STATUS_OUT_OF_MEM = 2'd2;
    localparam logic [1:0] STATUS_BAD_HANDLE = 2'd3;

    // input word
    typedef struct packed {
        logic        opcode;
        logic [31:0] request_bytes;
        logic [5:0]  release_handle;
    } fbpa_req_t;

    // result word
    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  granted_handle;
        logic [47:0] granted_address;
        logic [37:0] occupied_bytes;
        logic [6:0]  free_chunks;
    } fbpa_rsp_t;

    // sequencer states
    typedef enum logic [1:0] {
        FSM_SWEEP,
        FSM_IDLE,
        FSM_UPDATE,
        FSM_FINISH
    } fbpa_state_t;

    // sequencer to datapath controls
    typedef struct packed {
        logic sweep;
        logic ready;
        logic accept;
        logic update;
        logic finish;
    } fbpa_ctrl_t;

endpackage : fbpa_pkg
`default_nettype wire

// ===== rtl/core/fixed_block_pool_allocator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_unit
// Fixed-size chunk pool with a last-in first-out free list kept in RAM.
// A request reads the free-list and allocated-flag RAMs when accepted,
// writes back in the update state and loads its result in the finish state,
// which waits on a stalled result channel; no request is accepted before
// the last result is loaded. Reset and writes to chunk_bytes or chunks_in_use
// start a rebuild sweep of both RAMs; no request is accepted until it ends.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_unit
    import fbpa_pkg::*;
#(
    parameter int MAX_CHUNKS = 64
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // configuration
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    // request channel
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire fbpa_req_t              s_data,
    // result channel
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output fbpa_rsp_t                   m_data
);

    localparam int IDX_W  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CNT_W  = $clog2(MAX_CHUNKS + 1);
    localparam int PROD_W = IDX_W + 32;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_CHUNKS - 1);

    // configuration registers
    logic [31:0] chunk_bytes_reg;
    logic [6:0]  chunks_in_use_reg;
    logic [47:0] pool_base_reg;
    logic        reinit;

    assign reinit = cfg_we && ((cfg_index == CFG_CHUNK_BYTES) ||
                               (cfg_index == CFG_CHUNKS_IN_USE));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_bytes_reg   <= CHUNK_BYTES_RESET;
            chunks_in_use_reg <= CHUNKS_IN_USE_RESET;
            pool_base_reg     <= POOL_BASE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_CHUNK_BYTES:   chunk_bytes_reg   <= cfg_wdata[31:0];
                CFG_CHUNKS_IN_USE: chunks_in_use_reg <= cfg_wdata[6:0];
                CFG_POOL_BASE:     pool_base_reg     <= cfg_wdata[47:0];
                default:           ;
            endcase
        end
    end

    // effective pool size, saturated to the RAM depth
    logic [CNT_W-1:0] pool_count;

    assign pool_count = (32'(chunks_in_use_reg) > 32'(MAX_CHUNKS)) ?
                        CNT_W'(MAX_CHUNKS) : CNT_W'(chunks_in_use_reg);

    // sequencer
    fbpa_ctrl_t ctrl;
    logic       sweep_last;
    logic       out_free;

    assign out_free = !m_valid || m_ready;

    fbpa_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .reinit     (reinit),
        .sweep_last (sweep_last),
        .out_free   (out_free),
        .ctrl       (ctrl)
    );

    assign s_ready = ctrl.ready;

    // rebuild sweep index
    logic [IDX_W-1:0] sweep_idx_reg;
    logic [IDX_W-1:0] sweep_idx_next;

    assign sweep_last = (sweep_idx_reg == LAST_IDX);

    always_comb begin
        sweep_idx_next = sweep_idx_reg;
        if (reinit) begin
            sweep_idx_next = '0;
        end else if (ctrl.sweep && !sweep_last) begin
            sweep_idx_next = sweep_idx_reg + IDX_W'(1);
        end
    end

    // datapath registers
    logic [CNT_W-1:0]  top_reg,    top_next;
    logic [37:0]       occ_reg,    occ_next;
    fbpa_req_t         req_reg,    req_next;
    logic [1:0]        status_reg, status_next;
    logic              grant_reg,  grant_next;
    logic [IDX_W-1:0]  handle_reg, handle_next;
    logic [PROD_W-1:0] prod_reg,   prod_next;
    logic              m_valid_reg, m_valid_next;
    fbpa_rsp_t         m_data_reg,  m_data_next;

    // memory ports
    logic             stack_we;
    logic [IDX_W-1:0] stack_waddr;
    logic [IDX_W-1:0] stack_wdata;
    logic [IDX_W-1:0] stack_raddr;
    logic [IDX_W-1:0] stack_rdata;
    logic             flag_we;
    logic [IDX_W-1:0] flag_waddr;
    logic             flag_wdata;
    logic [IDX_W-1:0] flag_raddr;
    logic             flag_rdata;

    fbpa_ram #(
        .DATA_W (IDX_W),
        .DEPTH  (MAX_CHUNKS)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

    fbpa_ram #(
        .DATA_W (1),
        .DEPTH  (MAX_CHUNKS)
    ) u_flag_ram (
        .aclk  (aclk),
        .we    (flag_we),
        .waddr (flag_waddr),
        .wdata (flag_wdata),
        .raddr (flag_raddr),
        .rdata (flag_rdata)
    );

    // reads go out in the accept cycle, data returns in the update cycle
    assign stack_raddr = IDX_W'(top_reg - CNT_W'(1));
    assign flag_raddr  = IDX_W'(s_data.release_handle);

    // request decode on the latched word
    logic is_alloc;
    logic too_large;
    logic list_empty;
    logic rel_in_pool;
    logic free_ok;
    logic grant;

    assign is_alloc    = (req_reg.opcode == OP_ALLOC);
    assign too_large   = (req_reg.request_bytes > chunk_bytes_reg);
    assign list_empty  = (top_reg == '0);
    assign rel_in_pool = (32'(req_reg.release_handle) < 32'(pool_count));
    assign free_ok     = !is_alloc && rel_in_pool && flag_rdata;
    assign grant       = is_alloc && !too_large && !list_empty;

    // update and write-back
    always_comb begin
        top_next    = top_reg;
        occ_next    = occ_reg;
        req_next    = req_reg;
        status_next = status_reg;
        grant_next  = grant_reg;
        handle_next = handle_reg;
        prod_next   = prod_reg;
        stack_we    = 1'b0;
        stack_waddr = sweep_idx_reg;
        stack_wdata = IDX_W'(pool_count - CNT_W'(1) - CNT_W'(sweep_idx_reg));
        flag_we     = 1'b0;
        flag_waddr  = sweep_idx_reg;
        flag_wdata  = 1'b0;

        if (ctrl.accept) begin
            req_next = s_data;
        end

        priority if (ctrl.sweep) begin
            // rebuild: chunk 0 on top, all flags clear
            stack_we = 1'b1;
            flag_we  = 1'b1;
            top_next = pool_count;
            occ_next = '0;
        end else if (ctrl.update) begin
            grant_next  = grant;
            handle_next = grant ? stack_rdata : '0;
            prod_next   = PROD_W'(handle_next) * PROD_W'(chunk_bytes_reg);
            if (is_alloc) begin
                if (too_large) begin
                    status_next = STATUS_TOO_LARGE;
                end else if (list_empty) begin
                    status_next = STATUS_OUT_OF_MEM;
                end else begin
                    status_next = STATUS_OK;
                    top_next    = top_reg - CNT_W'(1);
                    occ_next    = occ_reg + 38'(chunk_bytes_reg);
                    flag_we     = 1'b1;
                    flag_waddr  = stack_rdata;
                    flag_wdata  = 1'b1;
                end
            end else if (free_ok) begin
                status_next = STATUS_OK;
                top_next    = top_reg + CNT_W'(1);
                occ_next    = occ_reg - 38'(chunk_bytes_reg);
                flag_we     = 1'b1;
                flag_waddr  = IDX_W'(req_reg.release_handle);
                flag_wdata  = 1'b0;
                stack_we    = 1'b1;
                stack_waddr = IDX_W'(top_reg);
                stack_wdata = IDX_W'(req_reg.release_handle);
            end else begin
                status_next = STATUS_BAD_HANDLE;
            end
        end else begin
            // hold
        end
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (ctrl.finish) begin
            m_valid_next                = 1'b1;
            m_data_next.status          = status_reg;
            m_data_next.granted_handle  = 6'(handle_reg);
            m_data_next.granted_address = grant_reg ?
                                          (pool_base_reg + 48'(prod_reg)) : 48'd0;
            m_data_next.occupied_bytes  = occ_reg;
            m_data_next.free_chunks     = 7'(top_reg);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_idx_reg <= '0;
            top_reg       <= '0;
            occ_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            sweep_idx_reg <= sweep_idx_next;
            top_reg       <= top_next;
            occ_reg       <= occ_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        status_reg <= status_next;
        grant_reg  <= grant_next;
        handle_reg <= handle_next;
        prod_reg   <= prod_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule : fixed_block_pool_allocator_unit
`default_nettype wire

// ===== rtl/core/fbpa_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module fbpa_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 64
) (
    input  wire logic                                   aclk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [DATA_W-1:0]                      wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [DATA_W-1:0]                      rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule : fbpa_ram
`default_nettype wire

// ===== rtl/core/fbpa_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_seq
// Request sequencer: runs the pool rebuild sweep, then steps each request
// through memory read, update/write-back and result load.
// ----------------------------------------------------------------------------
module fbpa_seq
    import fbpa_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    input  wire logic reinit,
    input  wire logic sweep_last,
    input  wire logic out_free,
    output fbpa_ctrl_t ctrl
);

    fbpa_state_t state_reg;
    fbpa_state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_SWEEP;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        if (reinit) begin
            state_next = FSM_SWEEP;
        end else begin
            unique case (state_reg)
                FSM_SWEEP: begin
                    if (sweep_last) begin
                        state_next = FSM_IDLE;
                    end
                end
                FSM_IDLE: begin
                    if (s_valid) begin
                        state_next = FSM_UPDATE;
                    end
                end
                FSM_UPDATE: begin
                    state_next = FSM_FINISH;
                end
                FSM_FINISH: begin
                    if (out_free) begin
                        state_next = s_valid ? FSM_UPDATE : FSM_IDLE;
                    end
                end
                default: begin
                    state_next = FSM_SWEEP;
                end
            endcase
        end
    end

    // control outputs
    always_comb begin
        ctrl.sweep  = (state_reg == FSM_SWEEP);
        ctrl.ready  = (state_reg == FSM_IDLE) || ((state_reg == FSM_FINISH) && out_free);
        ctrl.accept = ctrl.ready && s_valid;
        ctrl.update = (state_reg == FSM_UPDATE);
        ctrl.finish = (state_reg == FSM_FINISH) && out_free;
    end

endmodule : fbpa_seq
`default_nettype wire
